FILE: hw/rtl/lrsa_pkg.sv
// ----------------------------------------------------------------------------
// Left-right state alignment package
// Shared sizes, cost codes, sequencer states and the cell control struct.
// ----------------------------------------------------------------------------
package lrsa_pkg;

    localparam int MAX_FRAMES   = 1024;
    localparam int FRAME_IDX_W  = $clog2(MAX_FRAMES);
    localparam int FRAME_W      = $clog2(MAX_FRAMES + 1);
    localparam int MAX_STATES   = 16;
    localparam int STATE_W      = $clog2(MAX_STATES);
    localparam int STATE_CNT_W  = $clog2(MAX_STATES + 1);
    localparam int COST_W       = 48;
    localparam int LOCAL_W      = 32;
    localparam int STATES_RESET = 5;
    localparam int OUT_DATA_W   = 16;

    // Infinity code and the most negative cost of the accumulated Q32.16 costs.
    localparam logic signed [COST_W-1:0] COST_INF = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_ADD,
        ST_BT_RD,
        ST_BT_EV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic first_cell;
        logic state_zero;
        logic force_inf;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/lrsa_cost_unit.sv
// ----------------------------------------------------------------------------
// Left-right state alignment cost unit
// Picks stay or advance into a register, then adds the local cost with saturation.
// ----------------------------------------------------------------------------
module lrsa_cost_unit (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  lrsa_pkg::t_cell_ctl                   i_ctl,
    input  logic signed [lrsa_pkg::COST_W-1:0]    i_stay,
    input  logic signed [lrsa_pkg::COST_W-1:0]    i_adv,
    input  logic signed [lrsa_pkg::LOCAL_W-1:0]   i_local,
    output logic signed [lrsa_pkg::COST_W-1:0]    o_cost,
    output logic                                  o_advance
);

    logic signed [lrsa_pkg::COST_W-1:0]  r_base;
    logic signed [lrsa_pkg::LOCAL_W-1:0] r_local;
    logic                                r_inf;
    logic                                r_adv_pick;
    logic                                take_adv;
    logic signed [lrsa_pkg::COST_W:0]    sum;

    // A tie keeps the path in the same state.
    assign take_adv = !i_ctl.first_cell && !i_ctl.state_zero && !i_ctl.force_inf
                      && (i_stay > i_adv);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_ctl.first_cell) begin
                r_base <= '0;
            end else if (take_adv) begin
                r_base <= i_adv;
            end else begin
                r_base <= i_stay;
            end
            r_local    <= i_local;
            r_inf      <= i_ctl.force_inf;
            r_adv_pick <= take_adv;
        end
    end

    assign sum = (lrsa_pkg::COST_W+1)'(r_base) + (lrsa_pkg::COST_W+1)'(r_local);

    always_comb begin
        if (r_inf || (r_base == lrsa_pkg::COST_INF)) begin
            o_cost = lrsa_pkg::COST_INF;
        end else if (sum[lrsa_pkg::COST_W] != sum[lrsa_pkg::COST_W-1]) begin
            o_cost = sum[lrsa_pkg::COST_W] ? lrsa_pkg::COST_MIN : lrsa_pkg::COST_INF;
        end else begin
            o_cost = sum[lrsa_pkg::COST_W-1:0];
        end
    end

    assign o_advance = r_adv_pick;

endmodule

FILE: hw/rtl/left_right_state_alignment_unit.sv
// ----------------------------------------------------------------------------
// Left-right state alignment unit
// Fixed-point left-to-right Viterbi alignment of one utterance with backtrack.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Carries
// s         in         i_s_tvalid / o_s_tready  local cost (tdata), final cost (tlast)
// m         out        o_m_tvalid / i_m_tready  state index, boundary frame (tdata),
//                                               overflow (tuser), final boundary (tlast)
// cfg       in         i_cfg_valid / o_cfg_ready  number of states in use
//
// A cost request inside the frame capacity is handled in order: accept with the
// row store read, stay/advance selection, then the saturating add and writes.
// A cost beyond the frame capacity raises the overflow flag and is not stored.
// The backtrack alternates a decision memory read and a step for each frame,
// from the last frame down to frame 1, plus one more read that reaches
// frame 0. It then emits states_in_use + 1 boundary requests at one per cycle
// while the downstream side is ready.
// Reset is synchronous and active low; the stores need no clearing pass.
//
module left_right_state_alignment_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Cost stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] local_cost
    input  logic        i_s_tlast,   // last_cost
    // Boundary stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [4:0] state_index, [15:5] boundary_frame
    output logic        o_m_tuser,   // [0] frames_overflow
    output logic        o_m_tlast,   // last_boundary
    // Configuration.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data   // states_in_use
);

    localparam int FW  = lrsa_pkg::FRAME_W;
    localparam int FIW = lrsa_pkg::FRAME_IDX_W;
    localparam int SW  = lrsa_pkg::STATE_W;
    localparam int SCW = lrsa_pkg::STATE_CNT_W;
    localparam int CW  = lrsa_pkg::COST_W;

    lrsa_pkg::t_state r_fsm, n_fsm;

    logic [SCW-1:0]            r_states_cfg;
    logic [FW-1:0]             r_frame_cnt;
    logic [SW-1:0]             r_state_cnt;
    logic                      r_ovf;
    logic signed [31:0]        r_loc;
    logic                      r_last;
    logic signed [CW-1:0]      r_adv;
    logic [lrsa_pkg::MAX_STATES-1:0] r_row_bits;
    logic [FIW-1:0]            r_bt_inp;
    logic [SW-1:0]             r_bt_st;
    logic [FW-1:0]             r_count;
    logic                      r_bt_ovf;
    logic [SCW-1:0]            r_k;
    logic [FIW-1:0]            r_bounds [lrsa_pkg::MAX_STATES];

    logic                      r_m_valid;
    logic [SCW-1:0]            r_m_idx;
    logic [FW-1:0]             r_m_frame;
    logic                      r_m_ovf;
    logic                      r_m_last;

    // Row store of accumulated costs and the decision memory.
    logic signed [CW-1:0]      cost_mem [lrsa_pkg::MAX_STATES];
    logic signed [CW-1:0]      r_cost_rd;
    logic [lrsa_pkg::MAX_STATES-1:0] dec_mem [lrsa_pkg::MAX_FRAMES];
    logic [lrsa_pkg::MAX_STATES-1:0] r_dec_rd;

    logic [SCW-1:0]            n_used;
    logic                      s_acc;
    logic                      frame_in_range;
    logic                      unit_load;
    logic                      cell_write;
    logic                      step_done;
    logic                      step_last;
    logic                      step_ovf;
    logic                      load_out;
    logic [SCW-1:0]            state_next;
    logic [FW-1:0]             count_now;
    logic [FW+1:0]             two_f;
    lrsa_pkg::t_cell_ctl       cell_ctl;
    logic signed [CW-1:0]      unit_cost;
    logic                      unit_advance;
    logic [lrsa_pkg::MAX_STATES-1:0] row_word;
    logic [FW-1:0]             out_frame;

    // The register is used clamped to the range one up to the state capacity.
    always_comb begin
        if (r_states_cfg == '0) begin
            n_used = SCW'(1);
        end else if (r_states_cfg > SCW'(lrsa_pkg::MAX_STATES)) begin
            n_used = SCW'(lrsa_pkg::MAX_STATES);
        end else begin
            n_used = r_states_cfg;
        end
    end

    assign s_acc          = i_s_tvalid && o_s_tready;
    assign frame_in_range = r_frame_cnt < FW'(lrsa_pkg::MAX_FRAMES);

    // Next-state logic of the sequencer.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            lrsa_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (frame_in_range) begin
                        n_fsm = lrsa_pkg::ST_SEL;
                    end else if (i_s_tlast) begin
                        n_fsm = lrsa_pkg::ST_BT_RD;
                    end
                end
            end
            lrsa_pkg::ST_SEL: begin
                n_fsm = lrsa_pkg::ST_ADD;
            end
            lrsa_pkg::ST_ADD: begin
                n_fsm = r_last ? lrsa_pkg::ST_BT_RD : lrsa_pkg::ST_IDLE;
            end
            lrsa_pkg::ST_BT_RD: begin
                n_fsm = (r_bt_inp == '0) ? lrsa_pkg::ST_OUT : lrsa_pkg::ST_BT_EV;
            end
            lrsa_pkg::ST_BT_EV: begin
                n_fsm = lrsa_pkg::ST_BT_RD;
            end
            lrsa_pkg::ST_OUT: begin
                if (load_out && (r_k == n_used)) begin
                    n_fsm = lrsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_fsm = lrsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_s_tready = (r_fsm == lrsa_pkg::ST_IDLE);
        unit_load  = (r_fsm == lrsa_pkg::ST_SEL);
        cell_write = (r_fsm == lrsa_pkg::ST_ADD);
        load_out   = (r_fsm == lrsa_pkg::ST_OUT) && (!r_m_valid || i_m_tready);
    end

    // A step ends after the add for a frame in range, or right at the accept
    // for a frame beyond capacity, which raises the overflow flag and writes no cell.
    assign step_ovf  = s_acc && !frame_in_range;
    assign step_done = cell_write || step_ovf;
    assign step_last = cell_write ? r_last : i_s_tlast;
    assign state_next = SCW'(r_state_cnt) + SCW'(1);
    assign count_now  = frame_in_range ? (r_frame_cnt + FW'(1)) : FW'(lrsa_pkg::MAX_FRAMES);

    // Cells above twice the frame index cannot be reached and are infinite.
    assign two_f = {1'b0, r_frame_cnt, 1'b0};
    always_comb begin
        cell_ctl.first_cell = (r_frame_cnt == '0) && (r_state_cnt == '0);
        cell_ctl.state_zero = (r_state_cnt == '0);
        cell_ctl.force_inf  = (FW+2)'(r_state_cnt) > two_f;
    end

    lrsa_cost_unit u_cost (
        .i_clk     (i_clk),
        .i_load    (unit_load),
        .i_ctl     (cell_ctl),
        .i_stay    (r_cost_rd),
        .i_adv     (r_adv),
        .i_local   (r_loc),
        .o_cost    (unit_cost),
        .o_advance (unit_advance)
    );

    // Decision word of the current frame; a new row starts from all stays.
    always_comb begin
        row_word = (r_state_cnt == '0) ? '0 : r_row_bits;
        row_word = row_word | (lrsa_pkg::MAX_STATES'(unit_advance) << r_state_cnt);
    end

    always_ff @(posedge i_clk) begin
        r_cost_rd <= cost_mem[r_state_cnt];
        if (cell_write) begin
            cost_mem[r_state_cnt] <= unit_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec_rd <= dec_mem[r_bt_inp];
        if (cell_write) begin
            dec_mem[r_frame_cnt[FIW-1:0]] <= row_word;
        end
    end

    // Payload registers of the cell path and the backtrack.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_loc  <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        // The stay cost of this cell is the advance cost of the next one.
        if (unit_load) begin
            r_adv <= r_cost_rd;
        end
        if (cell_write) begin
            r_row_bits <= row_word;
        end
        if (step_done && step_last) begin
            r_count  <= count_now;
            r_bt_inp <= FIW'(count_now - FW'(1));
            r_bt_st  <= SW'(n_used - SCW'(1));
            r_bt_ovf <= r_ovf || step_ovf;
        end else if (r_fsm == lrsa_pkg::ST_BT_EV) begin
            r_bounds[r_bt_st] <= r_bt_inp;
            if ((r_bt_st != '0) && r_dec_rd[r_bt_st]) begin
                r_bt_st <= r_bt_st - SW'(1);
            end
            r_bt_inp <= r_bt_inp - FIW'(1);
        end
    end

    // States at or below the one reached at frame zero start at frame zero.
    always_comb begin
        if (r_k == n_used) begin
            out_frame = r_count;
        end else if (r_k[SW-1:0] <= r_bt_st) begin
            out_frame = '0;
        end else begin
            out_frame = FW'(r_bounds[r_k[SW-1:0]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_idx   <= r_k;
            r_m_frame <= out_frame;
            r_m_ovf   <= r_bt_ovf;
            r_m_last  <= (r_k == n_used);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= lrsa_pkg::ST_IDLE;
            r_states_cfg <= SCW'(lrsa_pkg::STATES_RESET);
            r_frame_cnt  <= '0;
            r_state_cnt  <= '0;
            r_ovf        <= 1'b0;
            r_k          <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid && o_cfg_ready) begin
                r_states_cfg <= i_cfg_data;
            end
            if (step_done) begin
                if (step_last) begin
                    r_frame_cnt <= '0;
                    r_state_cnt <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_ovf <= r_ovf || step_ovf;
                    // A row also ends when a smaller state count was written
                    // while the row was under way.
                    if (state_next >= n_used) begin
                        r_state_cnt <= '0;
                        if (frame_in_range) begin
                            r_frame_cnt <= r_frame_cnt + FW'(1);
                        end
                    end else begin
                        r_state_cnt <= r_state_cnt + SW'(1);
                    end
                end
            end
            if (r_fsm != lrsa_pkg::ST_OUT) begin
                r_k <= '0;
            end else if (load_out) begin
                r_k <= r_k + SCW'(1);
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {r_m_frame, r_m_idx};
    assign o_m_tuser   = r_m_ovf;
    assign o_m_tlast   = r_m_last;

`ifndef ASSERT_OFF
    a_cell_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && frame_in_range) |=> (r_fsm == lrsa_pkg::ST_SEL))
        else $error("cost in frame range did not enter the cell path");

    a_bt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == lrsa_pkg::ST_BT_EV) |-> (r_bt_inp != '0))
        else $error("backtrack stepped past frame zero");

    a_count_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[SCW-1:0] == n_used))
        else $error("frame count entry carries the wrong state index");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_fsm) == lrsa_pkg::ST_OUT))
        else $error("boundary request raised outside the output phase");
`endif

endmodule
